// ----- hw/rtl/ddsl_pkg.sv -----
// Package for the two-channel duty slew limiter: word types, command codes,
// register indexes and duty limits shared by the lanes, merge and top level.
// No dependencies.
package ddsl_pkg;

    localparam int DUTY_FRAC_BITS = 14;
    localparam int FULL_DUTY      = 1 << DUTY_FRAC_BITS;
    localparam int MIN_DUTY       = FULL_DUTY / 10;
    localparam int MIN_STEP       = FULL_DUTY / 1000;

    localparam int DUTY_W = 16;
    localparam int REG_W  = 15;
    localparam int IDX_W  = 2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_BRAKE = 2'd3
    } cmd_t;

    localparam logic [IDX_W-1:0] REG_DUTY_CAP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_RISE_STEP = 2'd1;
    localparam logic [IDX_W-1:0] REG_FALL_STEP = 2'd2;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [DUTY_W-1:0] req_left;
        logic signed [DUTY_W-1:0] req_right;
    } in_word_t;

    typedef struct packed {
        logic signed [DUTY_W-1:0] drive_m0;
        logic signed [DUTY_W-1:0] drive_m1;
        logic signed [DUTY_W-1:0] level_left;
        logic signed [DUTY_W-1:0] level_right;
        logic                     brake_now;
    } out_word_t;

    // Saturated limits handed from the register file to both lanes
    typedef struct packed {
        logic [REG_W-1:0] duty_cap;
        logic [REG_W-1:0] rise_step;
        logic [REG_W-1:0] fall_step;
    } limits_t;

endpackage

// ----- hw/rtl/ddsl_lane.sv -----
// One channel of the slew limiter: holds goal and level, clamps new goals
// and ramps the level on a tick. Depends on ddsl_pkg.
module ddsl_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  ddsl_pkg::cmd_t                    cmd,
    input  logic signed [ddsl_pkg::DUTY_W-1:0] target,
    input  ddsl_pkg::limits_t                 limits,
    output logic signed [ddsl_pkg::DUTY_W-1:0] level_next
);
    import ddsl_pkg::*;

    localparam int WIDE_W = DUTY_W + 2;

    logic signed [DUTY_W-1:0] goal_reg, goal_next;
    logic signed [DUTY_W-1:0] now_reg;
    logic signed [WIDE_W-1:0] now_w, goal_w, up_w, down_w, ramp_w;
    logic signed [DUTY_W:0]   tgt_w, max_w;
    logic signed [DUTY_W-1:0] clamped;

    // Clamp the requested goal to plus or minus the maximum duty
    always_comb
    begin
        tgt_w = {target[DUTY_W-1], target};
        max_w = {2'b00, limits.duty_cap};
        if (tgt_w > max_w)
            clamped = max_w[DUTY_W-1:0];
        else if (tgt_w < -max_w)
            clamped = DUTY_W'(-max_w);
        else
            clamped = target;
    end

    // Step toward the goal without passing it
    always_comb
    begin
        now_w  = WIDE_W'(now_reg);
        goal_w = WIDE_W'(goal_reg);
        up_w   = now_w + $signed({3'b000, limits.rise_step});
        down_w = now_w - $signed({3'b000, limits.fall_step});
        if (goal_w > now_w)
            ramp_w = (up_w < goal_w) ? up_w : goal_w;
        else if (goal_w < now_w)
            ramp_w = (down_w > goal_w) ? down_w : goal_w;
        else
            ramp_w = now_w;
    end

    // Select the next goal and level for this command
    always_comb
    begin
        goal_next  = goal_reg;
        level_next = now_reg;
        unique case (cmd)
            CMD_TICK:  level_next = ramp_w[DUTY_W-1:0];
            CMD_SET:   goal_next  = clamped;
            CMD_STOP:  goal_next  = '0;
            CMD_BRAKE:
            begin
                goal_next  = '0;
                level_next = '0;
            end
            default:   level_next = now_reg;
        endcase
    end

    // Hold the channel state, advance on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg <= '0;
            now_reg  <= '0;
        end
        else if (accept)
        begin
            goal_reg <= goal_next;
            now_reg  <= level_next;
        end
    end

endmodule

// ----- hw/rtl/ddsl_merge.sv -----
// Merge stage: builds the result word from both lanes and holds it in an
// output register with a skid entry. Depends on ddsl_pkg.
module ddsl_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  ddsl_pkg::cmd_t                     cmd,
    input  logic signed [ddsl_pkg::DUTY_W-1:0] level_left,
    input  logic signed [ddsl_pkg::DUTY_W-1:0] level_right,
    output logic                               room,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ddsl_pkg::out_word_t                out_data
);
    import ddsl_pkg::*;

    out_word_t word;
    out_word_t main_reg, skid_reg;
    logic      main_valid_reg, skid_valid_reg;
    logic      pop;

    // Combine the lane levels into one result word
    always_comb
    begin
        word.drive_m0    = level_left;
        word.drive_m1    = -level_right;
        word.level_left  = level_left;
        word.level_right = level_right;
        word.brake_now   = (cmd == CMD_BRAKE);
    end

    assign pop       = main_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Control: main register feeds the port, skid catches a word on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!main_valid_reg || pop)
                main_reg <= word;
            else
                skid_reg <= word;
        end
        else if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
    end

endmodule

// ----- hw/rtl/dual_duty_slew_limiter_core.sv -----
// Two-channel duty slew limiter: register file, two lanes, merge stage.
// Results are registered in the merge stage; lanes update on accept.
// Throughput: one word per cycle while the skid entry is free.
// A skid entry lets one more word in while a result is stalled.
// Reset (rst_n low, asynchronous): goals and levels zero, registers at
// duty cap 16384, rise and fall steps 164, output empty.
module dual_duty_slew_limiter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ddsl_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ddsl_pkg::out_word_t               out_data,
    input  logic                              cfg_we,
    input  logic [ddsl_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ddsl_pkg::REG_W-1:0]        cfg_data
);
    import ddsl_pkg::*;

    logic [REG_W-1:0]         duty_cap_reg, rise_step_reg, fall_step_reg;
    limits_t                  limits;
    logic                     accept;
    logic                     room;
    logic signed [DUTY_W-1:0] level_left, level_right;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_cap_reg  <= REG_W'(FULL_DUTY);
            rise_step_reg <= REG_W'(164);
            fall_step_reg <= REG_W'(164);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DUTY_CAP:  duty_cap_reg  <= cfg_data;
                REG_RISE_STEP: rise_step_reg <= cfg_data;
                REG_FALL_STEP: fall_step_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Saturate the registers to their usable ranges
    always_comb
    begin
        if (duty_cap_reg < REG_W'(MIN_DUTY))
            limits.duty_cap = REG_W'(MIN_DUTY);
        else if (duty_cap_reg > REG_W'(FULL_DUTY))
            limits.duty_cap = REG_W'(FULL_DUTY);
        else
            limits.duty_cap = duty_cap_reg;
        limits.rise_step = (rise_step_reg < REG_W'(MIN_STEP)) ? REG_W'(MIN_STEP)
                                                              : rise_step_reg;
        limits.fall_step = (fall_step_reg < REG_W'(MIN_STEP)) ? REG_W'(MIN_STEP)
                                                              : fall_step_reg;
    end

    assign in_ready = room;
    assign accept   = in_valid && room;

    ddsl_lane u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (in_data.cmd),
        .target     (in_data.req_left),
        .limits     (limits),
        .level_next (level_left)
    );

    ddsl_lane u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (in_data.cmd),
        .target     (in_data.req_right),
        .limits     (limits),
        .level_next (level_right)
    );

    ddsl_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .cmd         (in_data.cmd),
        .level_left  (level_left),
        .level_right (level_right),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
